FILE: hw/rtl/hlrd_pkg.sv
package hlrd_pkg;

  localparam int MaxServers = 8;
  localparam int SlotW = 3;
  localparam int CfgIdxW = 2;
  localparam int CfgDataW = 24;

  localparam logic [CfgIdxW-1:0] CFG_MASK    = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_BEAT    = 2'd1;
  localparam logic [CfgIdxW-1:0] CFG_TIMEOUT = 2'd2;

  localparam logic [23:0] BEAT_RESET    = 24'd500000;
  localparam logic [23:0] TIMEOUT_RESET = 24'd2000000;

  localparam logic [1:0] FUNC_TICK  = 2'd0;
  localparam logic [1:0] FUNC_BEAT  = 2'd1;
  localparam logic [1:0] FUNC_REPLY = 2'd2;
  localparam logic [1:0] FUNC_REQ   = 2'd3;

  localparam logic [1:0] KIND_HEARTBEAT = 2'd0;
  localparam logic [1:0] KIND_DISPATCH  = 2'd1;
  localparam logic [1:0] KIND_DELIVER   = 2'd2;

  typedef struct packed {
    logic [1:0]  func;
    logic [2:0]  server_slot;
    logic [31:0] reply_sequence;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [2:0]  target_slot;
    logic [31:0] sequence_res;
    logic        last;
  } out_item_t;

  // controller -> datapath commands
  typedef struct packed {
    logic       capture;   // latch the accepted request
    logic       load;      // apply input item
    logic       deliver;   // emit delivery
    logic       retire;    // abandon an overdue reply
    logic       beat_emit; // emit heartbeat for scan slot
    logic       beat_done; // rearm beat time
    logic       expire;    // drop expired server at scan slot
    logic       dispatch;  // emit dispatch, rotate LRU
    logic [2:0] slot;      // scan slot
    logic       last;
  } hlrd_cmd_t;

  // datapath -> controller status
  typedef struct packed {
    logic deliver_ok;
    logic beat_due;
    logic dispatch_ok;
  } hlrd_sts_t;

endpackage

FILE: hw/rtl/hlrd_datapath.sv
module hlrd_datapath (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_we,
  input  logic [1:0]          cfg_idx,
  input  logic [23:0]         cfg_data,
  input  hlrd_pkg::in_item_t  item,
  input  hlrd_pkg::hlrd_cmd_t cmd,
  output hlrd_pkg::hlrd_sts_t sts,
  output logic [7:0]          mask,
  output logic                out_valid,
  output hlrd_pkg::out_item_t out_item
);

  logic [7:0]  mask_r;
  logic [23:0] beat_r, tmo_r;
  logic [31:0] time_r, nbeat_r, rdl_r, seq_r;
  logic [7:0]  alive_r;
  logic [31:0] adl_r [8];
  logic [2:0]  lru_r [8];
  logic [3:0]  cnt_r;
  logic        pend_r, busy_r;
  logic [2:0]  bsrv_r;
  hlrd_pkg::in_item_t it_r;
  logic        ov_r;
  hlrd_pkg::out_item_t oi_r;

  logic conn_in;
  logic [31:0] d_exp;
  logic        exp_hit;
  logic [2:0]  pos;
  logic        found;

  assign conn_in = mask_r[it_r.server_slot];
  assign d_exp = time_r - adl_r[cmd.slot];
  assign exp_hit = alive_r[cmd.slot] && !d_exp[31];

  // position of scan slot in LRU order
  always_comb begin
    pos = 3'd0;
    found = 1'b0;
    for (int i = 0; i < 8; i++) begin
      if (!found && (4'(i) < cnt_r) && lru_r[i] == cmd.slot) begin
        pos = 3'(i);
        found = 1'b1;
      end
    end
  end

  logic [31:0] d_beat, d_rdl;
  assign d_beat = time_r - nbeat_r;
  assign d_rdl = time_r - rdl_r;

  assign sts.deliver_ok = (it_r.func == hlrd_pkg::FUNC_REPLY) && conn_in && busy_r &&
                          (bsrv_r == it_r.server_slot) && (it_r.reply_sequence == seq_r);
  assign sts.beat_due = !d_beat[31];
  // busy here already reflects expiry of late reply in earlier step
  assign sts.dispatch_ok = pend_r && !busy_r && (cnt_r != 4'd0);
  assign mask = mask_r;
  assign out_valid = ov_r;
  assign out_item = oi_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mask_r <= '0;
      beat_r <= hlrd_pkg::BEAT_RESET;
      tmo_r <= hlrd_pkg::TIMEOUT_RESET;
      time_r <= '0;
      nbeat_r <= '0;
      rdl_r <= '0;
      seq_r <= '0;
      alive_r <= '0;
      cnt_r <= '0;
      pend_r <= 1'b0;
      busy_r <= 1'b0;
      bsrv_r <= '0;
      ov_r <= 1'b0;
    end else begin
      ov_r <= 1'b0;
      if (cfg_we) begin
        case (cfg_idx)
          hlrd_pkg::CFG_MASK:    mask_r <= cfg_data[7:0];
          hlrd_pkg::CFG_BEAT:    beat_r <= cfg_data;
          hlrd_pkg::CFG_TIMEOUT: tmo_r <= cfg_data;
          default: ;
        endcase
      end
      // apply item
      if (cmd.load) begin
        case (it_r.func)
          hlrd_pkg::FUNC_TICK: time_r <= time_r + 32'd1;
          hlrd_pkg::FUNC_BEAT: begin
            if (conn_in) begin
              if (!alive_r[it_r.server_slot]) begin
                lru_r[cnt_r[2:0]] <= it_r.server_slot;
                cnt_r <= cnt_r + 4'd1;
                alive_r[it_r.server_slot] <= 1'b1;
              end
              adl_r[it_r.server_slot] <= time_r + {8'd0, beat_r};
            end
          end
          hlrd_pkg::FUNC_REQ: begin
            if (mask_r != 8'd0 && !pend_r && !busy_r) pend_r <= 1'b1;
          end
          default: ;
        endcase
      end
      if (cmd.deliver) begin
        ov_r <= 1'b1;
        oi_r <= '{hlrd_pkg::KIND_DELIVER, 3'd0, seq_r, cmd.last};
        seq_r <= seq_r + 32'd1;
        busy_r <= 1'b0;
        pend_r <= 1'b0;
      end
      // late reply is abandoned in the delivery step when nothing is delivered
      if (cmd.retire && busy_r && !d_rdl[31]) busy_r <= 1'b0;
      if (cmd.beat_emit) begin
        ov_r <= 1'b1;
        oi_r <= '{hlrd_pkg::KIND_HEARTBEAT, cmd.slot, 32'd0, cmd.last};
      end
      if (cmd.beat_done) nbeat_r <= time_r + {8'd0, beat_r};
      // drop expired server at the scan slot
      if (cmd.expire) begin
        if (exp_hit) begin
          alive_r[cmd.slot] <= 1'b0;
          if (found) begin
            for (int j = 0; j < 7; j++)
              if (3'(j) >= pos) lru_r[j] <= lru_r[j+1];
            cnt_r <= cnt_r - 4'd1;
          end
        end
      end
      if (cmd.dispatch) begin
        ov_r <= 1'b1;
        oi_r <= '{hlrd_pkg::KIND_DISPATCH, lru_r[0], seq_r, 1'b1};
        busy_r <= 1'b1;
        bsrv_r <= lru_r[0];
        rdl_r <= time_r + {8'd0, tmo_r};
        for (int j = 0; j < 7; j++)
          if (4'(j + 1) < cnt_r) lru_r[j] <= lru_r[j+1];
        lru_r[3'(cnt_r - 4'd1)] <= lru_r[0];
      end
    end
  end

  // request capture at acceptance
  always_ff @(posedge clk) begin
    if (cmd.capture) it_r <= item;
  end

endmodule

FILE: hw/rtl/hlrd_ctrl.sv
module hlrd_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  input  logic [7:0]          mask,
  input  hlrd_pkg::hlrd_sts_t sts,
  output hlrd_pkg::hlrd_cmd_t cmd,
  output logic                busy
);

  typedef enum logic [2:0] {
    S_IDLE, S_LOAD, S_DELIV, S_BEAT, S_EXP, S_DISP
  } state_t;

  state_t     state_r;
  logic [2:0] slot_r;

  // is there a connected slot above the scan slot
  logic more_conn;
  always_comb begin
    more_conn = 1'b0;
    for (int i = 0; i < 8; i++)
      if (3'(i) > slot_r && mask[i]) more_conn = 1'b1;
  end

  always_comb begin
    cmd = '0;
    cmd.slot = slot_r;
    case (state_r)
      S_IDLE: cmd.capture = start;
      S_LOAD: cmd.load = 1'b1;
      S_DELIV: begin
        cmd.deliver = sts.deliver_ok;
        cmd.retire = !sts.deliver_ok;
        cmd.last = !(sts.beat_due && mask != 8'd0) && !sts.dispatch_ok;
      end
      S_BEAT: begin
        cmd.beat_emit = mask[slot_r];
        cmd.beat_done = (slot_r == 3'd7);
        cmd.last = !more_conn && !sts.dispatch_ok;
      end
      S_EXP: cmd.expire = 1'b1;
      S_DISP: cmd.dispatch = sts.dispatch_ok;
      default: ;
    endcase
  end

  assign busy = (state_r != S_IDLE);

  // expiry scan runs before the broadcast so the dispatch decision is known
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      slot_r <= '0;
    end else begin
      case (state_r)
        S_IDLE: if (start) state_r <= S_LOAD;
        S_LOAD: begin
          slot_r <= '0;
          state_r <= S_EXP;
        end
        S_EXP: begin
          slot_r <= slot_r + 3'd1;
          if (slot_r == 3'd7) state_r <= S_DELIV;
        end
        S_DELIV: begin
          slot_r <= '0;
          state_r <= sts.beat_due ? S_BEAT : S_DISP;
        end
        S_BEAT: begin
          slot_r <= slot_r + 3'd1;
          if (slot_r == 3'd7) state_r <= S_DISP;
        end
        S_DISP: state_r <= S_IDLE;
        default: state_r <= S_IDLE;
      endcase
    end
  end

endmodule

FILE: hw/rtl/heartbeat_lru_request_dispatcher_top.sv
// Heartbeat LRU request dispatcher. A request is taken at an edge where start
// is high and busy is low; busy then stays high while it applies the request,
// runs the server expiry scan (one slot a cycle), does the delivery and
// late-reply check, runs the heartbeat broadcast when one is due and does the
// dispatch, so no new request is taken until the last is done. Each result is
// registered, appearing in the cycle after the step that makes it, at most one
// a cycle on out_valid, and the receiver cannot stall it; out_item.last marks
// the final one. Write configuration only while busy is low.
module heartbeat_lru_request_dispatcher_top (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  hlrd_pkg::in_item_t  in_item,
  output logic                out_valid,
  output hlrd_pkg::out_item_t out_item,
  input  logic                cfg_we,
  input  logic [1:0]          cfg_idx,
  input  logic [23:0]         cfg_data
);

  hlrd_pkg::hlrd_cmd_t cmd;
  hlrd_pkg::hlrd_sts_t sts;
  logic [7:0] mask;

  hlrd_ctrl u_ctrl (
    .clk, .rst_n, .start, .mask, .sts, .cmd, .busy
  );

  hlrd_datapath u_dp (
    .clk, .rst_n, .cfg_we, .cfg_idx, .cfg_data,
    .item(in_item), .cmd, .sts, .mask, .out_valid, .out_item
  );

  a_no_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy) else $error("busy not raised");
  a_load_after: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load |-> busy) else $error("load while idle");

endmodule

FILE: test/heartbeat_lru_request_dispatcher_top_tb.sv
module heartbeat_lru_request_dispatcher_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  logic clk;
  logic rst_n;
  logic start;
  logic busy;
  hlrd_pkg::in_item_t in_item;
  logic out_valid;
  hlrd_pkg::out_item_t out_item;
  logic cfg_we;
  logic [1:0] cfg_idx;
  logic [23:0] cfg_data;

  heartbeat_lru_request_dispatcher_top uut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .in_item(in_item),
    .out_valid(out_valid), .out_item(out_item), .cfg_we(cfg_we),
    .cfg_idx(cfg_idx), .cfg_data(cfg_data)
  );

  // shadow copy of the dispatcher state
  logic [7:0] m_mask;
  logic [31:0] m_beat_iv;
  logic [31:0] m_reply_to;
  logic [31:0] m_now;
  logic [31:0] m_next_beat;
  logic m_alive [hlrd_pkg::MaxServers];
  logic [31:0] m_alive_dl [hlrd_pkg::MaxServers];
  logic [2:0] m_lru [hlrd_pkg::MaxServers];
  int m_lru_n;
  logic m_pending;
  logic m_busy;
  logic [2:0] m_busy_slot;
  logic [31:0] m_reply_dl;
  logic [31:0] m_seq;

  hlrd_pkg::in_item_t request_q[$];
  hlrd_pkg::out_item_t expected_q[$];
  int errors;
  int results_seen;
  int requests_sent;
  bit driver_idle_ok;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    #50ms;
    $display("heartbeat_lru_request_dispatcher_top regression: fail");
    $finish;
  end

  function automatic bit past_due(logic [31:0] dl);
    logic [31:0] d;
    d = m_now - dl;
    return d[31] == 1'b0;
  endfunction

  function automatic bit slot_on(logic [2:0] s);
    return m_mask[s];
  endfunction

  function automatic void lru_drop(logic [2:0] s);
    for (int i = 0; i < m_lru_n; i++) begin
      if (m_lru[i] == s) begin
        for (int j = i; j + 1 < m_lru_n; j++) m_lru[j] = m_lru[j+1];
        m_lru_n--;
        return;
      end
    end
  endfunction

  function automatic void lru_push(logic [2:0] s);
    if (m_lru_n < hlrd_pkg::MaxServers) begin
      m_lru[m_lru_n] = s;
      m_lru_n++;
    end
  endfunction

  function automatic void push_result(logic [1:0] k, logic [2:0] s, logic [31:0] q);
    hlrd_pkg::out_item_t r;
    r.kind = k;
    r.target_slot = s;
    r.sequence_res = q;
    r.last = 1'b0;
    expected_q.push_back(r);
  endfunction

  // predict the results of one accepted request
  function automatic void predict_dispatch(hlrd_pkg::in_item_t it);
    int n_prior;
    logic [2:0] head;
    n_prior = expected_q.size();
    case (it.func)
      hlrd_pkg::FUNC_TICK: m_now++;
      hlrd_pkg::FUNC_BEAT: begin
        if (slot_on(it.server_slot)) begin
          if (!m_alive[it.server_slot]) begin
            lru_push(it.server_slot);
            m_alive[it.server_slot] = 1'b1;
          end
          m_alive_dl[it.server_slot] = m_now + m_beat_iv;
        end
      end
      hlrd_pkg::FUNC_REPLY: begin
        if (slot_on(it.server_slot) && m_busy && m_busy_slot == it.server_slot &&
            it.reply_sequence == m_seq) begin
          push_result(hlrd_pkg::KIND_DELIVER, 3'd0, m_seq);
          m_seq++;
          m_busy = 1'b0;
          m_pending = 1'b0;
        end
      end
      default: begin
        if (m_mask != 0 && !m_pending && !m_busy) m_pending = 1'b1;
      end
    endcase
    // heartbeat broadcast
    if (past_due(m_next_beat)) begin
      for (int s = 0; s < hlrd_pkg::MaxServers; s++)
        if (slot_on(3'(s))) push_result(hlrd_pkg::KIND_HEARTBEAT, 3'(s), 32'd0);
      m_next_beat = m_now + m_beat_iv;
    end
    // expiry scan
    for (int s = 0; s < hlrd_pkg::MaxServers; s++) begin
      if (m_alive[s] && past_due(m_alive_dl[s])) begin
        m_alive[s] = 1'b0;
        lru_drop(3'(s));
      end
    end
    if (m_busy && past_due(m_reply_dl)) m_busy = 1'b0;
    // dispatch to LRU head
    if (m_pending && !m_busy && m_lru_n > 0) begin
      head = m_lru[0];
      push_result(hlrd_pkg::KIND_DISPATCH, head, m_seq);
      m_busy = 1'b1;
      m_busy_slot = head;
      m_reply_dl = m_now + m_reply_to;
      lru_drop(head);
      lru_push(head);
    end
    if (expected_q.size() > n_prior) expected_q[$].last = 1'b1;
  endfunction

  // driver: one request from the queue when the block is free
  always @(negedge clk) begin
    if (!rst_n) begin
      start <= 1'b0;
    end else if (start) begin
      // raised while idle, so accepted at the last rising edge
      start <= 1'b0;
    end else if (!busy) begin
      if (request_q.size() > 0 && (driver_idle_ok ? $urandom_range(99) >= 24 : 1)) begin
        in_item <= request_q.pop_front();
        start <= 1'b1;
      end
    end
  end

  // monitor: prediction on acceptance, check on each result
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid) begin
        results_seen++;
        if (expected_q.size() == 0) begin
          errors++;
          if (errors <= 10) $display("unexpected result %p", out_item);
        end else begin
          hlrd_pkg::out_item_t e;
          e = expected_q.pop_front();
          if (e !== out_item) begin
            errors++;
            if (errors <= 10)
              $display("mismatch: expected %p got %p", e, out_item);
          end
        end
      end
      if (start && !busy) begin
        predict_dispatch(in_item);
        requests_sent++;
      end
    end
  end

  task automatic write_reg(logic [1:0] idx, logic [23:0] val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_data <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    case (idx)
      hlrd_pkg::CFG_MASK: m_mask = val[7:0];
      hlrd_pkg::CFG_BEAT: m_beat_iv = {8'd0, val};
      default: m_reply_to = {8'd0, val};
    endcase
  endtask

  // wait until every queued request is accepted and all results are in
  task automatic drain();
    while (request_q.size() > 0 || start || busy || expected_q.size() > 0)
      @(negedge clk);
    repeat (30) @(negedge clk);
  endtask

  function automatic hlrd_pkg::in_item_t mk(logic [1:0] f, logic [2:0] s, logic [31:0] q);
    hlrd_pkg::in_item_t it;
    it.func = f;
    it.server_slot = s;
    it.reply_sequence = q;
    return it;
  endfunction

  // well-formed cycle: heartbeats, request, ticks, then a reply (slot guessed at random)
  task automatic queue_session(int ticks_max);
    logic [31:0] q;
    for (int s = 0; s < hlrd_pkg::MaxServers; s++)
      if ($urandom_range(1)) request_q.push_back(mk(hlrd_pkg::FUNC_BEAT, 3'(s), $urandom));
    request_q.push_back(mk(hlrd_pkg::FUNC_REQ, 3'($urandom), $urandom));
    repeat ($urandom_range(ticks_max))
      request_q.push_back(mk(hlrd_pkg::FUNC_TICK, 3'($urandom), $urandom));
    // reply to a random slot, mostly with the sequence number known now, else a random one
    q = ($urandom_range(3) == 0) ? $urandom : m_seq;
    request_q.push_back(mk(hlrd_pkg::FUNC_REPLY, 3'($urandom), q));
  endtask

  initial begin
    int phase;
    rst_n = 1'b0;
    start = 1'b0;
    in_item = '0;
    cfg_we = 1'b0;
    cfg_idx = hlrd_pkg::CFG_MASK;
    cfg_data = '0;
    errors = 0;
    results_seen = 0;
    requests_sent = 0;
    driver_idle_ok = 1'b0;
    m_mask = 0;
    m_beat_iv = {8'd0, hlrd_pkg::BEAT_RESET};
    m_reply_to = {8'd0, hlrd_pkg::TIMEOUT_RESET};
    m_now = 0;
    m_next_beat = 0;
    m_lru_n = 0;
    m_pending = 0;
    m_busy = 0;
    m_busy_slot = 0;
    m_reply_dl = 0;
    m_seq = 0;
    for (int i = 0; i < hlrd_pkg::MaxServers; i++) begin
      m_alive[i] = 0;
      m_alive_dl[i] = 0;
      m_lru[i] = 0;
    end
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // directed: nothing connected, then full mask and extremes
    request_q.push_back(mk(hlrd_pkg::FUNC_TICK, 3'd0, 32'd0));
    request_q.push_back(mk(hlrd_pkg::FUNC_REQ, 3'd7, 32'hFFFF_FFFF));
    request_q.push_back(mk(hlrd_pkg::FUNC_BEAT, 3'd7, 32'd0));
    drain();
    write_reg(hlrd_pkg::CFG_MASK, 24'hFF);
    write_reg(hlrd_pkg::CFG_BEAT, 24'd3);
    write_reg(hlrd_pkg::CFG_TIMEOUT, 24'd4);
    request_q.push_back(mk(hlrd_pkg::FUNC_BEAT, 3'd0, 32'd0));
    request_q.push_back(mk(hlrd_pkg::FUNC_BEAT, 3'd7, 32'd0));
    request_q.push_back(mk(hlrd_pkg::FUNC_REQ, 3'd0, 32'd0));
    request_q.push_back(mk(hlrd_pkg::FUNC_REPLY, 3'd7, 32'd0));
    request_q.push_back(mk(hlrd_pkg::FUNC_REPLY, 3'd0, 32'd0));
    request_q.push_back(mk(hlrd_pkg::FUNC_REQ, 3'd0, 32'd0));
    request_q.push_back(mk(hlrd_pkg::FUNC_REQ, 3'd0, 32'd0));
    repeat (5) request_q.push_back(mk(hlrd_pkg::FUNC_TICK, 3'd5, 32'hFFFF_FFFF));
    request_q.push_back(mk(hlrd_pkg::FUNC_REPLY, 3'd7, 32'hFFFF_FFFF));
    drain();
    // mask cleared while servers alive; minimum intervals
    write_reg(hlrd_pkg::CFG_MASK, 24'h00);
    write_reg(hlrd_pkg::CFG_BEAT, 24'd1);
    write_reg(hlrd_pkg::CFG_TIMEOUT, 24'd1);
    request_q.push_back(mk(hlrd_pkg::FUNC_REQ, 3'd1, 32'd0));
    request_q.push_back(mk(hlrd_pkg::FUNC_TICK, 3'd1, 32'd0));
    request_q.push_back(mk(hlrd_pkg::FUNC_TICK, 3'd1, 32'd0));
    drain();
    write_reg(hlrd_pkg::CFG_BEAT, 24'hFF_FFFF);
    write_reg(hlrd_pkg::CFG_TIMEOUT, 24'hFF_FFFF);
    write_reg(hlrd_pkg::CFG_MASK, 24'hA5);
    request_q.push_back(mk(hlrd_pkg::FUNC_BEAT, 3'd2, 32'd0));
    request_q.push_back(mk(hlrd_pkg::FUNC_REQ, 3'd0, 32'd0));
    request_q.push_back(mk(hlrd_pkg::FUNC_REPLY, 3'd2, 32'd1));
    drain();

    // random phases with varied settings
    driver_idle_ok = 1'b0;
    for (phase = 0; phase < 8; phase++) begin
      write_reg(hlrd_pkg::CFG_MASK, 24'($urandom_range(255)));
      write_reg(hlrd_pkg::CFG_BEAT,
                (phase == 7) ? 24'hFF_FFFF : 24'($urandom_range(1, 12)));
      write_reg(hlrd_pkg::CFG_TIMEOUT,
                (phase == 6) ? 24'hFF_FFFF : 24'($urandom_range(1, 16)));
      for (int k = 0; k < 5; k++) begin
        queue_session(6);
        drain();
        // reply with the right slot now that the predictor knows it
        if (m_busy && $urandom_range(3) != 0)
          request_q.push_back(mk(hlrd_pkg::FUNC_REPLY, m_busy_slot,
                                 $urandom_range(4) == 0 ? $urandom : m_seq));
        repeat ($urandom_range(2))
          request_q.push_back(mk(2'($urandom), 3'($urandom), $urandom));
        drain();
      end
      driver_idle_ok = 1'b1;
    end

    $display("covered %0d requests and %0d results over several register settings",
             requests_sent, results_seen);
    if (errors == 0 && expected_q.size() == 0)
      $display("heartbeat_lru_request_dispatcher_top regression: pass");
    else
      $display("heartbeat_lru_request_dispatcher_top regression: fail");
    $finish;
  end

endmodule
